>>> rtl/collision_manifold_2d_core_assert.svh
// Assertion macros used by the checker file.
`ifndef COLLISION_MANIFOLD_2D_CORE_ASSERT_SVH
`define COLLISION_MANIFOLD_2D_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/cm2d_pkg.sv
// ----------------------------------------------------------------------------
// cm2d_pkg
// Types and constants shared by the collision manifold pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package cm2d_pkg;
	localparam int ONE_Q14 = 16384;
	localparam int SQRT_BITS = 34;
	localparam int QUO_BITS = 15;
	localparam int PIPE_DEPTH = 2 + SQRT_BITS + 1 + QUO_BITS + 1;

	typedef enum logic [1:0] {
		KIND_CC = 2'd0,
		KIND_CB = 2'd1,
		KIND_BC = 2'd2,
		KIND_BB = 2'd3
	} kind_t;

	// Per-item result and control carried along the pipeline.
	typedef struct packed {
		logic        hit;
		logic        fixed;    // normal and depth already final
		logic        in_box;   // negate vector (circle centre inside box)
		logic        sx;       // sign of normal x before negation
		logic        sy;
		logic [32:0] mx;       // magnitude of vector x
		logic [32:0] my;
		logic [32:0] rad;      // radius or radius sum for penetration
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [31:0] pen;
	} item_t;
endpackage
`default_nettype wire

>>> rtl/cm2d_front.sv
// ----------------------------------------------------------------------------
// cm2d_front
// Offset, clamp, box-box test and squared length: two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module cm2d_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_v,
	input  wire logic [1:0]          req_type,
	input  wire logic signed [31:0]  pos_a_x,
	input  wire logic signed [31:0]  pos_a_y,
	input  wire logic signed [31:0]  pos_b_x,
	input  wire logic signed [31:0]  pos_b_y,
	input  wire logic [30:0]         half_w_a,
	input  wire logic [30:0]         half_h_a,
	input  wire logic [30:0]         half_w_b,
	input  wire logic [30:0]         half_h_b,
	input  wire logic [30:0]         radius_a,
	input  wire logic [30:0]         radius_b,
	output logic                     out_v,
	output cm2d_pkg::item_t          out_item,
	output logic [67:0]              out_d2
);
	// Stage 1 registers.
	logic               v_s1;
	logic [1:0]         kind_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic [30:0]        hwa_s1, hha_s1, hwb_s1, hhb_s1, ra_s1, rb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= req_type;
			dx_s1 <= 33'(pos_b_x) - 33'(pos_a_x);
			dy_s1 <= 33'(pos_b_y) - 33'(pos_a_y);
			hwa_s1 <= half_w_a;
			hha_s1 <= half_h_a;
			hwb_s1 <= half_w_b;
			hhb_s1 <= half_h_b;
			ra_s1 <= radius_a;
			rb_s1 <= radius_b;
		end
	end

	// Stage 2 logic: build the vector to normalise.
	logic [32:0] adx, ady, ex, ey, r, mvx, mvy;
	logic signed [34:0] vx, vy, cx, cy, ox, oy;
	logic in_box, in_x, in_y;
	cm2d_pkg::item_t it;

	always_comb begin
		adx = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		ady = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		ex = (kind_s1 == cm2d_pkg::KIND_CB) ? {2'b0, hwb_s1} : {2'b0, hwa_s1};
		ey = (kind_s1 == cm2d_pkg::KIND_CB) ? {2'b0, hhb_s1} : {2'b0, hha_s1};
		r = (kind_s1 == cm2d_pkg::KIND_CB) ? {2'b0, ra_s1} : {2'b0, rb_s1};
		in_x = adx <= ex;
		in_y = ady <= ey;
		cx = in_x ? 35'(dx_s1) : (dx_s1[32] ? -35'(ex) : 35'(ex));
		cy = in_y ? 35'(dy_s1) : (dy_s1[32] ? -35'(ey) : 35'(ey));
		in_box = in_x && in_y;
		if (in_box) begin
			// Push the clamp point to the face on the axis of the larger offset; a tie goes to y.
			if (adx > ady) begin
				cx = (dx_s1 > 0) ? 35'(ex) : -35'(ex);
			end else begin
				cy = (dy_s1 > 0) ? 35'(ey) : -35'(ey);
			end
		end
		vx = 35'(dx_s1) - cx;
		vy = 35'(dy_s1) - cy;
		it = '0;
		ox = 35'(hwa_s1) + 35'(hwb_s1) - 35'(adx);
		oy = 35'(hha_s1) + 35'(hhb_s1) - 35'(ady);
		case (kind_s1)
			cm2d_pkg::KIND_CC: begin
				it.mx = adx;
				it.my = ady;
				it.sx = dx_s1[32];
				it.sy = dy_s1[32];
				it.rad = 33'(ra_s1) + 33'(rb_s1);
				if (dx_s1 == '0 && dy_s1 == '0) begin
					it.fixed = 1'b1;
					it.hit = 1'b1;
					it.nx = 16'(cm2d_pkg::ONE_Q14);
					it.pen = 32'(ra_s1);
				end
			end
			cm2d_pkg::KIND_BB: begin
				it.fixed = 1'b1;
				// The overlap is positive here and saturates at the top of the range.
				if (ox > 0 && oy > 0) begin
					it.hit = 1'b1;
					if (ox < oy) begin
						it.nx = dx_s1[32] ? -16'(cm2d_pkg::ONE_Q14) : 16'(cm2d_pkg::ONE_Q14);
						it.pen = (ox > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF : 32'(ox);
					end else begin
						it.ny = dy_s1[32] ? -16'(cm2d_pkg::ONE_Q14) : 16'(cm2d_pkg::ONE_Q14);
						it.pen = (oy > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF : 32'(oy);
					end
				end
			end
			default: begin
				mvx = vx[34] ? 33'(-vx) : 33'(vx);
				mvy = vy[34] ? 33'(-vy) : 33'(vy);
				it.mx = mvx;
				it.my = mvy;
				it.in_box = in_box;
				it.sx = vx[34] ^ in_box && (vx != '0);
				it.sy = vy[34] ^ in_box && (vy != '0);
				it.rad = r;
			end
		endcase
		mvx = it.mx;
		mvy = it.my;
	end

	// Stage 2 registers: squares are registered before the sum.
	logic [65:0] sqx_s2, sqy_s2;
	logic        v_s2;
	cm2d_pkg::item_t it_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it;
			sqx_s2 <= 66'(mvx) * 66'(mvx);
			sqy_s2 <= 66'(mvy) * 66'(mvy);
		end
	end

	// Sum of squares and hit test against the radius squared.
	logic [67:0] d2;
	logic [67:0] r2;
	always_comb begin
		d2 = 68'(sqx_s2) + 68'(sqy_s2);
		r2 = 68'(it_s2.rad) * 68'(it_s2.rad);
		out_item = it_s2;
		if (!it_s2.fixed) begin
			out_item.hit = it_s2.in_box || (d2 <= r2);
		end
		out_d2 = d2;
		out_v = v_s2;
	end
endmodule
`default_nettype wire

>>> rtl/cm2d_sqrt.sv
// ----------------------------------------------------------------------------
// cm2d_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module cm2d_sqrt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  cm2d_pkg::item_t      in_item,
	input  wire logic [67:0]     in_d2,
	output logic                 out_v,
	output cm2d_pkg::item_t      out_item,
	output logic [33:0]          out_root
);
	localparam int N = cm2d_pkg::SQRT_BITS;

	logic              v_s [N+1];
	cm2d_pkg::item_t   it_s [N+1];
	logic [67:0]       rem_s [N+1];
	logic [33:0]       root_s [N+1];

	always_comb begin
		v_s[0] = in_v;
		it_s[0] = in_item;
		rem_s[0] = in_d2;
		root_s[0] = '0;
	end

	// Each stage decides one bit, from the top: remainder holds n - root^2.
	for (genvar g = 0; g < N; g++) begin : g_bit
		localparam int B = N - 1 - g;
		logic [69:0] trial;
		logic        v_q;
		always_comb begin
			trial = (70'(root_s[g]) << (B + 1)) + (70'(1) << (2 * B));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_s[g+1] <= it_s[g];
				if (trial <= 70'(rem_s[g])) begin
					rem_s[g+1] <= rem_s[g] - 68'(trial);
					root_s[g+1] <= root_s[g] | (34'(1) << B);
				end else begin
					rem_s[g+1] <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
		assign v_s[g+1] = v_q;
	end

	assign out_v = v_s[N];
	assign out_item = it_s[N];
	assign out_root = root_s[N];
endmodule
`default_nettype wire

>>> rtl/cm2d_norm.sv
// ----------------------------------------------------------------------------
// cm2d_norm
// Pipelined dividers for both normal components and the final result stage.
// ----------------------------------------------------------------------------
`default_nettype none
module cm2d_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  cm2d_pkg::item_t      in_item,
	input  wire logic [33:0]     in_root,
	output logic                 out_v,
	output cm2d_pkg::item_t      out_item
);
	localparam int N = cm2d_pkg::QUO_BITS;

	// Dividend 2*m*16384 + dist, divisor 2*dist, gives rounding to nearest.
	logic              v_s [N+2];
	cm2d_pkg::item_t   it_s [N+2];
	logic [35:0]       dv_s [N+2];
	logic [34:0]       ds_s [N+2];
	logic [49:0]       rx_s [N+2], ry_s [N+2];
	logic [14:0]       qx_s [N+2], qy_s [N+2];
	logic              v_q0;

	// Entry stage: form dividends and penetration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q0 <= 1'b0;
		end else if (en) begin
			v_q0 <= in_v;
		end
	end

	logic signed [35:0] pen_w;
	cm2d_pkg::item_t    ent;
	always_comb begin
		pen_w = 36'(in_item.rad) - 36'(in_root);
		ent = in_item;
		if (!in_item.fixed) begin
			ent.pen = (pen_w > 36'sh7FFFFFFF) ? 32'sh7FFFFFFF :
				(pen_w < -36'sh80000000) ? 32'sh80000000 : 32'(pen_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[1] <= ent;
			ds_s[1] <= {in_root, 1'b0};
			rx_s[1] <= {2'b0, in_item.mx, 15'b0} + 50'(in_root);
			ry_s[1] <= {2'b0, in_item.my, 15'b0} + 50'(in_root);
			qx_s[1] <= '0;
			qy_s[1] <= '0;
		end
	end
	assign v_s[1] = v_q0;
	assign dv_s[1] = '0;
	assign v_s[0] = 1'b0;
	assign it_s[0] = '0;
	assign dv_s[0] = '0;
	assign ds_s[0] = '0;
	assign rx_s[0] = '0;
	assign ry_s[0] = '0;
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;

	// Restoring division stages; the quotient does not exceed 16384 unless the divisor is zero.
	for (genvar g = 1; g <= N; g++) begin : g_div
		localparam int B = N - g;
		logic [49:0] tx;
		logic        v_q;
		assign tx = 50'(ds_s[g]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_s[g+1] <= it_s[g];
				ds_s[g+1] <= ds_s[g];
				if (rx_s[g] >= tx) begin
					rx_s[g+1] <= rx_s[g] - tx;
					qx_s[g+1] <= qx_s[g] | (15'(1) << B);
				end else begin
					rx_s[g+1] <= rx_s[g];
					qx_s[g+1] <= qx_s[g];
				end
				if (ry_s[g] >= tx) begin
					ry_s[g+1] <= ry_s[g] - tx;
					qy_s[g+1] <= qy_s[g] | (15'(1) << B);
				end else begin
					ry_s[g+1] <= ry_s[g];
					qy_s[g+1] <= qy_s[g];
				end
			end
		end
		assign v_s[g+1] = v_q;
		assign dv_s[g+1] = dv_s[g];
	end

	// Output stage: apply signs, zero the normal for a zero divisor, zero the fields of a miss.
	logic            v_o;
	cm2d_pkg::item_t it_o;
	cm2d_pkg::item_t fin;
	logic            zero_d;
	always_comb begin
		fin = it_s[N+1];
		zero_d = (ds_s[N+1] == '0) || (dv_s[N+1] != '0);
		if (!fin.fixed) begin
			fin.nx = zero_d ? 16'sd0 :
				(fin.sx ? -16'(qx_s[N+1]) : 16'(qx_s[N+1]));
			fin.ny = zero_d ? 16'sd0 :
				(fin.sy ? -16'(qy_s[N+1]) : 16'(qy_s[N+1]));
		end
		if (!fin.hit) begin
			fin.nx = '0;
			fin.ny = '0;
			fin.pen = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_s[N+1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			it_o <= fin;
		end
	end

	assign out_v = v_o;
	assign out_item = it_o;
endmodule
`default_nettype wire

>>> rtl/collision_manifold_2d_core.sv
// ----------------------------------------------------------------------------
// collision_manifold_2d_core
// Narrow-phase circle and box pair test with normal and penetration depth.
// ----------------------------------------------------------------------------
// One pair test is accepted per clock while the pipeline is not stalled; it passes
// through two front stages, a 34-stage square root, a 16-stage rounding divider and
// an output register. The pipeline advances as a whole whenever the output
// register is empty or its beat is being taken, so a stall freezes every stage.
`default_nettype none
module collision_manifold_2d_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          req_type,
	input  wire logic signed [31:0]  pos_a_x,
	input  wire logic signed [31:0]  pos_a_y,
	input  wire logic signed [31:0]  pos_b_x,
	input  wire logic signed [31:0]  pos_b_y,
	input  wire logic [30:0]         half_w_a,
	input  wire logic [30:0]         half_h_a,
	input  wire logic [30:0]         half_w_b,
	input  wire logic [30:0]         half_h_b,
	input  wire logic [30:0]         radius_a,
	input  wire logic [30:0]         radius_b,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     hit,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic signed [31:0]       penetration
);
	logic en;
	logic f_v, s_v, n_v;
	cm2d_pkg::item_t f_it, s_it, n_it;
	logic [67:0] f_d2;
	logic [33:0] s_root;

	// Whole pipeline moves when the last stage can hand over its beat.
	assign en = !n_v || out_ready;
	assign in_ready = en;

	cm2d_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid && en),
		.req_type(req_type), .pos_a_x(pos_a_x), .pos_a_y(pos_a_y),
		.pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
		.half_w_a(half_w_a), .half_h_a(half_h_a),
		.half_w_b(half_w_b), .half_h_b(half_h_b),
		.radius_a(radius_a), .radius_b(radius_b),
		.out_v(f_v), .out_item(f_it), .out_d2(f_d2)
	);

	cm2d_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(f_v), .in_item(f_it),
		.in_d2(f_d2), .out_v(s_v), .out_item(s_it), .out_root(s_root)
	);

	cm2d_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(s_v), .in_item(s_it),
		.in_root(s_root), .out_v(n_v), .out_item(n_it)
	);

	assign out_valid = n_v;
	assign hit = n_it.hit;
	assign normal_x = n_it.nx;
	assign normal_y = n_it.ny;
	assign penetration = n_it.pen;
endmodule
`default_nettype wire

>>> rtl/cm2d_checker.sv
// ----------------------------------------------------------------------------
// cm2d_checker
// Port-level checks on the collision manifold core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "collision_manifold_2d_core_assert.svh"
module cm2d_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic signed [15:0] normal_x,
	input wire logic signed [15:0] normal_y,
	input wire logic signed [31:0] penetration
);
	// A miss carries no normal and no depth.
	`CM_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !hit,
		normal_x == 16'sd0 && normal_y == 16'sd0 && penetration == 32'sd0)
	// Normal components never exceed one.
	`CM_ASSERT_IMP(a_norm_range, clk, arst_n, out_valid,
		normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
		normal_y <= 16'sd16384 && normal_y >= -16'sd16384)
	// Input side is ready whenever the output is free.
	`CM_ASSERT_IMP(a_ready, clk, arst_n, !out_valid || out_ready, in_ready)
	// A stalled result holds its hit flag and penetration.
	`CM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(hit) && $stable(penetration))
endmodule

bind collision_manifold_2d_core cm2d_checker u_cm2d_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .hit(hit), .normal_x(normal_x), .normal_y(normal_y),
	.penetration(penetration)
);
`default_nettype wire
